// ===== hw/rtl/lcdc_pkg.sv =====
// Shared types and constants of the LCD controller register port.
`timescale 1ns / 1ps
package lcdc_pkg;

    localparam int LCDC_RAM_COLUMNS = 32;
    localparam int LCDC_RAM_ROWS    = 64;

    localparam int CTRL_NARROW_BIT   = 6;
    localparam int CTRL_COL_STEP_BIT = 7;
    localparam int BANK_WIDTH        = 96;
    localparam int LINE_BITS         = 5;
    localparam int XW                = 13;

    localparam logic [2:0] IDX_DATA    = 3'd0;
    localparam logic [2:0] IDX_COLUMN  = 3'd1;
    localparam logic [2:0] IDX_ROW     = 3'd2;
    localparam logic [2:0] IDX_CONTROL = 3'd3;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_HOLD
    } lcdc_state_t;

    typedef struct packed {
        logic capture;
    } lcdc_cmd_t;

endpackage

// ===== hw/rtl/lcd_controller_register_port.sv =====
// Top level of the LCD controller register port.
// An accepted input beat's result is registered and offered in the next cycle.
// One beat per cycle while m_tready stays high, set by the single output register that
// the controller refills in the same cycle the held result is taken.
// Reset: aresetn clears the index, control, column and row registers and
// empties the output; display RAM contents stay undefined until written.
`timescale 1ns / 1ps
module lcd_controller_register_port
    import lcdc_pkg::*;
#(
    parameter int RAM_COLUMNS = LCDC_RAM_COLUMNS,
    parameter int RAM_ROWS    = LCDC_RAM_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // write_data
    input  logic [1:0]  s_tuser,   // operation, addr_odd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data, pixel_x, pixel_y, pixel_bits, zero pad
    output logic [1:0]  m_tuser    // pixel_valid, pixel_wide
);

    lcdc_cmd_t  cmd;
    logic [7:0] read_data;
    logic       pixel_valid;
    logic [9:0] pixel_x;
    logic [4:0] pixel_y;
    logic [7:0] pixel_bits;
    logic       pixel_wide;

    lcdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lcdc_datapath #(
        .RAM_COLUMNS (RAM_COLUMNS),
        .RAM_ROWS    (RAM_ROWS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .operation   (s_tuser[0]),
        .addr_odd    (s_tuser[1]),
        .write_data  (s_tdata),
        .read_data   (read_data),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_bits  (pixel_bits),
        .pixel_wide  (pixel_wide)
    );

    assign m_tdata = {1'b0, pixel_bits, pixel_y, pixel_x, read_data};
    assign m_tuser = {pixel_wide, pixel_valid};

endmodule

// ===== hw/rtl/lcdc_ctrl.sv =====
// Handshake controller: accepts beats and holds the result until taken.
`timescale 1ns / 1ps
module lcdc_ctrl
    import lcdc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output lcdc_cmd_t cmd
);

    lcdc_state_t state_reg;
    lcdc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                m_tvalid    = 1'b1;
                s_tready    = m_tready;
                cmd.capture = s_tvalid && m_tready;
                if (m_tready && !s_tvalid) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lcdc_datapath.sv =====
// Register file, display RAM and pixel run computation.
`timescale 1ns / 1ps
module lcdc_datapath
    import lcdc_pkg::*;
#(
    parameter int RAM_COLUMNS = LCDC_RAM_COLUMNS,
    parameter int RAM_ROWS    = LCDC_RAM_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  lcdc_cmd_t   cmd,
    input  logic        operation,
    input  logic        addr_odd,
    input  logic [7:0]  write_data,
    output logic [7:0]  read_data,
    output logic        pixel_valid,
    output logic [9:0]  pixel_x,
    output logic [4:0]  pixel_y,
    output logic [7:0]  pixel_bits,
    output logic        pixel_wide
);

    localparam int DEPTH = RAM_COLUMNS * RAM_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0] display_ram [DEPTH];

    logic [7:0] index_reg,   index_next;
    logic [7:0] control_reg, control_next;
    logic [7:0] column_reg,  column_next;
    logic [7:0] row_reg,     row_next;

    logic [7:0] read_data_reg,   read_data_next;
    logic       pixel_valid_reg, pixel_valid_next;
    logic [9:0] pixel_x_reg,     pixel_x_next;
    logic [4:0] pixel_y_reg,     pixel_y_next;
    logic [7:0] pixel_bits_reg,  pixel_bits_next;
    logic       pixel_wide_reg,  pixel_wide_next;

    logic          data_write;
    logic          in_range;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [XW-1:0] base_x;
    logic [XW-1:0] narrow_x;
    logic [XW-1:0] wide_x;

    assign data_write = operation == OP_WRITE && addr_odd && index_reg[2:0] == IDX_DATA;
    assign in_range   = ({1'b0, column_reg} < 9'(RAM_COLUMNS))
                     && ({1'b0, row_reg} < 9'(RAM_ROWS));
    assign ram_we     = cmd.capture && data_write && in_range;
    assign ram_addr   = AW'(32'(row_reg) * 32'(RAM_COLUMNS) + 32'(column_reg));
    assign base_x     = XW'(row_reg[7:LINE_BITS]) * XW'(BANK_WIDTH);
    assign narrow_x   = base_x + XW'(column_reg) * XW'(6) - XW'(36);
    assign wide_x     = base_x + XW'(column_reg) * XW'(8) - XW'(36);

    always_comb begin
        index_next       = index_reg;
        control_next     = control_reg;
        column_next      = column_reg;
        row_next         = row_reg;
        read_data_next   = 8'd0;
        pixel_valid_next = 1'b0;
        pixel_x_next     = 10'd0;
        pixel_y_next     = 5'd0;
        pixel_bits_next  = 8'd0;
        pixel_wide_next  = 1'b0;
        if (operation == OP_READ) begin
            read_data_next = addr_odd ? 8'd0 : index_reg;
        end else if (!addr_odd) begin
            index_next = write_data;
        end else begin
            case (index_reg[2:0])
                IDX_DATA: begin
                    if (in_range) begin
                        if (control_reg[CTRL_NARROW_BIT]) begin
                            if (column_reg >= 8'd6) begin
                                pixel_valid_next = 1'b1;
                                pixel_x_next     = narrow_x[9:0];
                                pixel_y_next     = row_reg[LINE_BITS-1:0];
                                pixel_bits_next  = {2'b00, write_data[5:0]};
                            end
                        end else if (column_reg >= 8'd4) begin
                            pixel_valid_next = 1'b1;
                            pixel_x_next     = wide_x[9:0];
                            pixel_y_next     = row_reg[LINE_BITS-1:0];
                            pixel_bits_next  = write_data;
                            pixel_wide_next  = 1'b1;
                        end
                    end
                    if (control_reg[CTRL_COL_STEP_BIT]) begin
                        column_next = column_reg + 8'd1;
                    end else begin
                        row_next = row_reg + 8'd1;
                    end
                end
                IDX_COLUMN:  column_next  = write_data;
                IDX_ROW:     row_next     = write_data;
                IDX_CONTROL: control_next = write_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg   <= 8'd0;
            control_reg <= 8'd0;
            column_reg  <= 8'd0;
            row_reg     <= 8'd0;
        end else if (cmd.capture) begin
            index_reg   <= index_next;
            control_reg <= control_next;
            column_reg  <= column_next;
            row_reg     <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            read_data_reg   <= read_data_next;
            pixel_valid_reg <= pixel_valid_next;
            pixel_x_reg     <= pixel_x_next;
            pixel_y_reg     <= pixel_y_next;
            pixel_bits_reg  <= pixel_bits_next;
            pixel_wide_reg  <= pixel_wide_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            display_ram[ram_addr] <= write_data;
        end
    end

    assign read_data   = read_data_reg;
    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_bits  = pixel_bits_reg;
    assign pixel_wide  = pixel_wide_reg;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the LCD controller register port.
`timescale 1ns / 1ps

import lcdc_pkg::*;

typedef struct packed {
    logic [7:0]        read_data;
    logic              pixel_valid;
    logic signed [9:0] pixel_x;
    logic [4:0]        pixel_y;
    logic [7:0]        pixel_bits;
    logic              pixel_wide;
} port_result_t;

class lcd_port_model;
    logic [7:0] index_q   = '0;
    logic [7:0] control_q = '0;
    logic [7:0] column_q  = '0;
    logic [7:0] row_q     = '0;
    port_result_t pending_results[$];
    int mismatches  = 0;
    int accesses    = 0;
    int reads       = 0;
    int wide_runs   = 0;
    int narrow_runs = 0;

    function port_result_t display_write(logic [7:0] wdata);
        port_result_t r;
        int col;
        int row;
        int base;
        r   = '0;
        col = column_q;
        row = row_q;
        if (col < LCDC_RAM_COLUMNS && row < LCDC_RAM_ROWS) begin
            base = (row / (1 << LINE_BITS)) * BANK_WIDTH;
            if (control_q[CTRL_NARROW_BIT]) begin
                if (col >= 6) begin
                    r.pixel_valid = 1'b1;
                    r.pixel_x     = 10'(base + (col - 6) * 6);
                    r.pixel_y     = row_q[LINE_BITS-1:0];
                    r.pixel_bits  = {2'b00, wdata[5:0]};
                    narrow_runs++;
                end
            end else if (col >= 4) begin
                r.pixel_valid = 1'b1;
                r.pixel_x     = 10'(base + (col - 4) * 8 - 4);
                r.pixel_y     = row_q[LINE_BITS-1:0];
                r.pixel_bits  = wdata;
                r.pixel_wide  = 1'b1;
                wide_runs++;
            end
        end
        if (control_q[CTRL_COL_STEP_BIT]) column_q = column_q + 8'd1;
        else row_q = row_q + 8'd1;
        return r;
    endfunction

    function void predict_access(logic op, logic odd, logic [7:0] wdata);
        port_result_t r;
        r = '0;
        accesses++;
        if (op == OP_READ) begin
            reads++;
            r.read_data = odd ? 8'h00 : index_q;
        end else if (!odd) begin
            index_q = wdata;
        end else begin
            case (index_q[2:0])
                IDX_DATA:    r = display_write(wdata);
                IDX_COLUMN:  column_q = wdata;
                IDX_ROW:     row_q = wdata;
                IDX_CONTROL: control_q = wdata;
                default: ;
            endcase
        end
        pending_results.push_back(r);
    endfunction

    function void compare_result(logic [31:0] data, logic [1:0] flags);
        port_result_t exp;
        port_result_t act;
        act.read_data   = data[7:0];
        act.pixel_x     = data[17:8];
        act.pixel_y     = data[22:18];
        act.pixel_bits  = data[30:23];
        act.pixel_valid = flags[0];
        act.pixel_wide  = flags[1];
        if (pending_results.size() == 0) begin
            $error("Unexpected result beat: tdata %h tuser %b", data, flags);
            mismatches++;
            return;
        end
        exp = pending_results.pop_front();
        if (act.read_data !== exp.read_data) begin
            $error("read_data expected %0d got %0d", exp.read_data, act.read_data);
            mismatches++;
        end
        if (act.pixel_valid !== exp.pixel_valid) begin
            $error("pixel_valid expected %0d got %0d", exp.pixel_valid, act.pixel_valid);
            mismatches++;
        end
        if (act.pixel_x !== exp.pixel_x) begin
            $error("pixel_x expected %0d got %0d", exp.pixel_x, act.pixel_x);
            mismatches++;
        end
        if (act.pixel_y !== exp.pixel_y) begin
            $error("pixel_y expected %0d got %0d", exp.pixel_y, act.pixel_y);
            mismatches++;
        end
        if (act.pixel_bits !== exp.pixel_bits) begin
            $error("pixel_bits expected %h got %h", exp.pixel_bits, act.pixel_bits);
            mismatches++;
        end
        if (act.pixel_wide !== exp.pixel_wide) begin
            $error("pixel_wide expected %0d got %0d", exp.pixel_wide, act.pixel_wide);
            mismatches++;
        end
    endfunction
endclass

module tb;
    localparam int RANDOM_BEATS = 1350;
    localparam int CYCLE_LIMIT  = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    bit idles_on = 1'b1;
    int beats_sent = 0;
    int cycle_count = 0;
    lcd_port_model port_model = new();

    lcd_controller_register_port DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL lcd_controller_register_port");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= !(idles_on && $urandom_range(0, 99) < 17);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) port_model.compare_result(m_tdata, m_tuser);
    end

    task automatic send_beat(input logic op, input logic odd, input logic [7:0] data);
        while (idles_on && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {odd, op};
        do @(posedge aclk); while (!s_tready);
        port_model.predict_access(op, odd, data);
        beats_sent++;
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [7:0] value);
        send_beat(OP_WRITE, 1'b0, {5'($urandom), idx});
        send_beat(OP_WRITE, 1'b1, value);
    endtask

    task automatic write_burst();
        int n;
        logic [7:0] col;
        logic [7:0] row;
        n   = $urandom_range(1, 10);
        col = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 35));
        case ($urandom_range(0, 7))
            0: row = 8'($urandom);
            1: row = 8'($urandom_range(250, 255));
            default: row = 8'($urandom_range(0, 66));
        endcase
        if ($urandom_range(0, 3) != 0) set_register(IDX_CONTROL, 8'($urandom));
        set_register(IDX_COLUMN, col);
        set_register(IDX_ROW, row);
        send_beat(OP_WRITE, 1'b0, {5'($urandom), IDX_DATA});
        repeat (n) begin
            send_beat(OP_WRITE, 1'b1, 8'($urandom));
            if ($urandom_range(0, 9) == 0) send_beat(OP_READ, 1'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(OP_READ, 1'b0, 8'h00);
        send_beat(OP_READ, 1'b1, 8'hFF);
        send_beat(OP_WRITE, 1'b0, 8'hFF);
        send_beat(OP_WRITE, 1'b1, 8'h5A);
        send_beat(OP_READ, 1'b0, 8'h00);
        send_beat(OP_WRITE, 1'b0, {5'b00000, IDX_COLUMN});
        send_beat(OP_WRITE, 1'b1, 8'd4);
        send_beat(OP_WRITE, 1'b0, {5'b11111, IDX_DATA});
        send_beat(OP_WRITE, 1'b1, 8'hFF);
        set_register(IDX_CONTROL, 8'hC0);
        set_register(IDX_COLUMN, 8'd5);
        send_beat(OP_WRITE, 1'b0, {5'b10101, IDX_DATA});
        send_beat(OP_WRITE, 1'b1, 8'h3F);
        send_beat(OP_WRITE, 1'b1, 8'hFF);
        set_register(IDX_COLUMN, 8'd31);
        set_register(IDX_ROW, 8'd63);
        send_beat(OP_WRITE, 1'b0, {5'b00000, IDX_DATA});
        send_beat(OP_WRITE, 1'b1, 8'h81);
        send_beat(OP_WRITE, 1'b1, 8'h42);
        set_register(IDX_COLUMN, 8'd255);
        send_beat(OP_WRITE, 1'b0, {5'b01010, IDX_DATA});
        send_beat(OP_WRITE, 1'b1, 8'hC3);
        send_beat(OP_WRITE, 1'b1, 8'h24);

        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            idles_on = !(beats_sent >= 500 && beats_sent < 800);
            if ($urandom_range(0, 99) < 75) write_burst();
            else send_beat(1'($urandom), 1'($urandom), 8'($urandom));
        end
        idles_on = 1'b1;
        s_tvalid <= 1'b0;

        while (port_model.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Run covered %0d bus beats, %0d of them reads.",
                 port_model.accesses, port_model.reads);
        $display("Display writes produced %0d wide and %0d narrow pixel runs.",
                 port_model.wide_runs, port_model.narrow_runs);
        if (port_model.mismatches == 0 && port_model.pending_results.size() == 0) begin
            $display("PASS lcd_controller_register_port");
        end else begin
            $display("FAIL lcd_controller_register_port");
        end
        $finish;
    end
endmodule
